@@ rtl/mvva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvva_pkg
// Shared types and constants of the mixed voronoi vertex area core.
// ----------------------------------------------------------------------------
package mvva_pkg;

   localparam int VERTEX_COUNT = 1024;
   localparam int ADDR_W       = $clog2(VERTEX_COUNT);
   localparam int IDX_W        = 10;
   localparam int COORD_W      = 24;
   localparam int AREA_W       = 48;
   localparam int POS_W        = 3 * COORD_W;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int ACC_W        = PROD_W + 2;
   localparam int HALF_W       = ACC_W / 2;
   localparam int WIDE_W       = 2 * ACC_W;
   localparam int DEN_SHIFT    = 11;
   localparam int DEN_W        = ACC_W + DEN_SHIFT;
   localparam int CNT_W        = $clog2(WIDE_W);

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_TRI  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_NOP  = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_TRI,
      OP_READ
   } op_type;

   typedef struct packed {
      logic [1:0]               command;
      logic [IDX_W-1:0]         index_a;
      logic [IDX_W-1:0]         index_b;
      logic [IDX_W-1:0]         index_c;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [AREA_W-1:0] area_value;
      logic              saturated;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] ia;
      logic [IDX_W-1:0] ib;
      logic [IDX_W-1:0] ic;
      logic [POS_W-1:0] pos;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

@@ rtl/mixed_voronoi_vertex_area_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_voronoi_vertex_area_core
// Mixed voronoi cell area accumulator over a triangle mesh.
//
// A transaction is taken when start is high and busy is low. Commands: load
// a vertex position (clears its area), add a triangle, read a vertex area.
// Only a read gives a response: rsp_strobe marks rsp_payload for one cycle,
// registered after the read leaves the queue and the area memory is read;
// the receiver cannot stall.
// A two-entry queue sits in front of the execution unit, so up to two
// transactions are taken while one is executing.
// A degenerate triangle (zero root) ends after the square root; a non-acute
// triangle skips the division, while an acute one also runs the divider for
// each corner. The triangle time is set by the shared 26x26 multiplier (four
// partial products per wide product), the one-bit-per-cycle square root
// and the bit-serial divider.
// After reset the area memory is cleared one entry per cycle, during which
// busy stays high.
// ----------------------------------------------------------------------------
module mixed_voronoi_vertex_area_core import mvva_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_payload,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   queue_out_type   q_out;
   back_status_type status;

   mvva_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .q_out       (q_out),
      .status      (status)
   );

   mvva_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_in        (q_out),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/mvva_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvva_front
// Accepts and decodes transactions and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mvva_front import mvva_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  req_type         req_payload,
   output logic            busy,
   output queue_out_type   q_out,
   input  back_status_type status
);

   item_type   entry_ff [2];
   item_type   entry_in [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] count_ff, count_in;
   logic       accept, push;
   item_type   dec;

   assign busy   = (count_ff == 2'd2) || status.clearing;
   assign accept = start && !busy;

   always_comb begin
      dec.ia  = req_payload.index_a;
      dec.ib  = req_payload.index_b;
      dec.ic  = req_payload.index_c;
      dec.pos = {req_payload.coord_x, req_payload.coord_y, req_payload.coord_z};
      dec.op  = OP_LOAD;
      push    = 1'b0;
      unique case (req_payload.command)
         CMD_LOAD: begin
            dec.op = OP_LOAD;
            push   = accept;
         end
         CMD_TRI: begin
            dec.op = OP_TRI;
            push   = accept;
         end
         CMD_READ: begin
            dec.op = OP_READ;
            push   = accept;
         end
         default: push = 1'b0;
      endcase
   end

   always_comb begin
      entry_in[0] = entry_ff[0];
      entry_in[1] = entry_ff[1];
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      count_in    = count_ff;
      if (push) begin
         entry_in[wp_ff] = dec;
         wp_in           = !wp_ff;
      end
      if (status.pop) begin
         rp_in = !rp_ff;
      end
      if (push && !status.pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && status.pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = entry_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue overfilled");
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> busy) else $error("full queue not busy");

endmodule

@@ rtl/mvva_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvva_back
// Executes queued transactions: position and area memories, triangle geometry
// with a shared multiplier, bit-serial square root and division.
// ----------------------------------------------------------------------------
module mvva_back import mvva_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  queue_out_type   q_in,
   output back_status_type status,
   output logic            rsp_strobe,
   output rsp_type         rsp_payload
);

   typedef enum logic [14:0] {
      S_CLEAR  = 15'b000000000000001,
      S_IDLE   = 15'b000000000000010,
      S_RD_A   = 15'b000000000000100,
      S_RD_B   = 15'b000000000001000,
      S_RD_C   = 15'b000000000010000,
      S_DIFF   = 15'b000000000100000,
      S_DOT    = 15'b000000001000000,
      S_MLOAD  = 15'b000000010000000,
      S_MRUN   = 15'b000000100000000,
      S_SQRT   = 15'b000001000000000,
      S_DECIDE = 15'b000010000000000,
      S_CORNER = 15'b000100000000000,
      S_DIV    = 15'b001000000000000,
      S_RMW_RD = 15'b010000000000000,
      S_RMW_WR = 15'b100000000000000
   } state_type;

   localparam state_type S_RSP_ALIAS = S_IDLE;

   state_type state_ff, state_in;
   logic      rsp_pend_ff, rsp_pend_in;
   item_type  item_ff, item_in;

   logic [POS_W-1:0]    pos_mem [VERTEX_COUNT];
   logic [POS_W-1:0]    pos_q_ff;
   logic                pos_we;
   logic [ADDR_W-1:0]   pos_wa, pos_ra;
   logic [AREA_W:0]     area_mem [VERTEX_COUNT];
   logic [AREA_W:0]     area_q_ff, area_wd;
   logic                area_we;
   logic [ADDR_W-1:0]   area_wa, area_ra;
   logic [ADDR_W-1:0]   clr_ff, clr_in;

   logic [POS_W-1:0]          pa_ff, pa_in, pb_ff, pb_in;
   logic signed [DIFF_W-1:0]  u_ff [3], u_in [3], v_ff [3], v_in [3], w_ff [3], w_in [3];
   logic signed [ACC_W-1:0]   acc_ff [9], acc_in [9];
   logic                      phase2_ff, phase2_in;
   logic [1:0]                k_ff, k_in;
   logic [2:0]                j_ff, j_in;

   logic signed [DIFF_W-1:0]  dot_a, dot_b;
   logic [3:0]                dot_dst;
   logic                      dot_neg;
   logic signed [PROD_W-1:0]  dot_p;
   logic signed [ACC_W-1:0]   dot_ext;

   logic [ACC_W-1:0]   mac_a_ff, mac_a_in, mac_b_ff, mac_b_in;
   logic [1:0]         part_ff, part_in;
   logic [2:0]         job_ff, job_in;
   logic [WIDE_W-1:0]  mac_acc_ff, mac_acc_in, mac_next, mac_sh;
   logic [HALF_W-1:0]  mac_ha, mac_hb;
   logic [ACC_W-1:0]   mac_p;
   logic [WIDE_W-1:0]  n_ff, n_in;
   logic [WIDE_W-1:0]  t_ff [3], t_in [3];

   logic [ACC_W-1:0]   root_ff, root_in;
   logic [ACC_W+3:0]   srem_ff, srem_in, srem_sh, strial;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               acute_ff, acute_in;

   logic [WIDE_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]   drem_ff, drem_in, den;
   logic [DEN_W:0]     dr, dr_sub;
   logic               dge;
   logic [AREA_W-1:0]  quot_ff, quot_in, quot_nx;
   logic               dover_ff, dover_in, dover_nx;
   logic [AREA_W-1:0]  g_ff, g_in;
   logic               gover_ff, gover_in;
   logic [1:0]         corner_ff, corner_in;
   logic [IDX_W-1:0]   cid;
   logic signed [ACC_W-1:0] dcor;
   logic [AREA_W:0]    gsum;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      return {1'b0, idx} < (IDX_W+1)'(VERTEX_COUNT);
   endfunction

   function automatic logic signed [DIFF_W-1:0] crd(input logic [POS_W-1:0] p,
                                                     input int m);
      logic [COORD_W-1:0] c;
      c = p[POS_W-1-m*COORD_W -: COORD_W];
      return {c[COORD_W-1], c};
   endfunction

   function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] x);
      return x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
   endfunction

   function automatic logic positive(input logic signed [ACC_W-1:0] x);
      return !x[ACC_W-1] && (x != '0);
   endfunction

   // memories
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wa] <= item_in.pos;
      end
      pos_q_ff <= pos_mem[pos_ra];
   end

   always_ff @(posedge clock) begin
      if (area_we) begin
         area_mem[area_wa] <= area_wd;
      end
      area_q_ff <= area_mem[area_ra];
   end

   // dot and cross product operand selection
   always_comb begin
      dot_a   = u_ff[0];
      dot_b   = u_ff[0];
      dot_dst = 4'd0;
      dot_neg = 1'b0;
      if (!phase2_ff) begin
         unique case (j_ff)
            3'd0: begin dot_a = u_ff[k_ff]; dot_b = u_ff[k_ff]; dot_dst = 4'd0; end
            3'd1: begin dot_a = v_ff[k_ff]; dot_b = v_ff[k_ff]; dot_dst = 4'd1; end
            3'd2: begin dot_a = w_ff[k_ff]; dot_b = w_ff[k_ff]; dot_dst = 4'd2; end
            3'd3: begin dot_a = u_ff[k_ff]; dot_b = v_ff[k_ff]; dot_dst = 4'd3; end
            3'd4: begin
               dot_a = u_ff[k_ff]; dot_b = w_ff[k_ff]; dot_dst = 4'd4; dot_neg = 1'b1;
            end
            3'd5: begin dot_a = v_ff[k_ff]; dot_b = w_ff[k_ff]; dot_dst = 4'd5; end
            default: dot_dst = 4'd0;
         endcase
      end else begin
         unique case (j_ff)
            3'd0: begin dot_a = u_ff[1]; dot_b = v_ff[2]; dot_dst = 4'd6; end
            3'd1: begin dot_a = u_ff[2]; dot_b = v_ff[1]; dot_dst = 4'd6; dot_neg = 1'b1; end
            3'd2: begin dot_a = u_ff[2]; dot_b = v_ff[0]; dot_dst = 4'd7; end
            3'd3: begin dot_a = u_ff[0]; dot_b = v_ff[2]; dot_dst = 4'd7; dot_neg = 1'b1; end
            3'd4: begin dot_a = u_ff[0]; dot_b = v_ff[1]; dot_dst = 4'd8; end
            3'd5: begin dot_a = u_ff[1]; dot_b = v_ff[0]; dot_dst = 4'd8; dot_neg = 1'b1; end
            default: dot_dst = 4'd6;
         endcase
      end
      dot_p   = dot_a * dot_b;
      dot_ext = {{(ACC_W-PROD_W){dot_p[PROD_W-1]}}, dot_p};
   end

   // shared wide multiplier, one half-by-half partial product per cycle
   always_comb begin
      mac_ha = part_ff[1] ? mac_a_ff[ACC_W-1:HALF_W] : mac_a_ff[HALF_W-1:0];
      mac_hb = part_ff[0] ? mac_b_ff[ACC_W-1:HALF_W] : mac_b_ff[HALF_W-1:0];
      mac_p  = mac_ha * mac_hb;
      unique case (part_ff)
         2'd0:    mac_sh = WIDE_W'(mac_p);
         2'd3:    mac_sh = WIDE_W'(mac_p) << (2 * HALF_W);
         default: mac_sh = WIDE_W'(mac_p) << HALF_W;
      endcase
      mac_next = mac_acc_ff + mac_sh;
   end

   // square root and division steps
   always_comb begin
      srem_sh = {srem_ff[ACC_W+1:0], n_ff[WIDE_W-1 -: 2]};
      strial  = {2'b00, root_ff, 2'b01};
      den     = {root_ff, DEN_SHIFT'(0)};
      dr      = {drem_ff, num_ff[WIDE_W-1]};
      dge     = dr >= {1'b0, den};
      dr_sub  = dr - {1'b0, den};
      dover_nx = dover_ff || (dge && (cnt_ff >= CNT_W'(AREA_W)));
      quot_nx  = (cnt_ff < CNT_W'(AREA_W)) ? {quot_ff[AREA_W-2:0], dge} : quot_ff;
      unique case (corner_ff)
         2'd0:    begin cid = item_ff.ia; dcor = acc_ff[3]; end
         2'd1:    begin cid = item_ff.ib; dcor = acc_ff[4]; end
         default: begin cid = item_ff.ic; dcor = acc_ff[5]; end
      endcase
      gsum = {1'b0, area_q_ff[AREA_W-1:0]} + {1'b0, g_ff};
   end

   always_comb begin
      state_in      = state_ff;
      rsp_pend_in   = 1'b0;
      item_in       = item_ff;
      clr_in        = clr_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      for (int i = 0; i < 3; i++) begin
         u_in[i] = u_ff[i];
         v_in[i] = v_ff[i];
         w_in[i] = w_ff[i];
         t_in[i] = t_ff[i];
      end
      for (int i = 0; i < 9; i++) begin
         acc_in[i] = acc_ff[i];
      end
      phase2_in     = phase2_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      mac_a_in      = mac_a_ff;
      mac_b_in      = mac_b_ff;
      part_in       = part_ff;
      job_in        = job_ff;
      mac_acc_in    = mac_acc_ff;
      n_in          = n_ff;
      root_in       = root_ff;
      srem_in       = srem_ff;
      cnt_in        = cnt_ff;
      acute_in      = acute_ff;
      num_in        = num_ff;
      drem_in       = drem_ff;
      quot_in       = quot_ff;
      dover_in      = dover_ff;
      g_in          = g_ff;
      gover_in      = gover_ff;
      corner_in     = corner_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      pos_we        = 1'b0;
      pos_wa        = q_in.item.ia[ADDR_W-1:0];
      pos_ra        = item_ff.ia[ADDR_W-1:0];
      area_we       = 1'b0;
      area_wa       = clr_ff;
      area_wd       = '0;
      area_ra       = cid[ADDR_W-1:0];
      status.pop      = 1'b0;
      status.clearing = (state_ff == S_CLEAR);

      unique case (state_ff)
         S_CLEAR: begin
            area_we = 1'b1;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(VERTEX_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (rsp_pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in.area_value = area_q_ff[AREA_W-1:0];
               rsp_in.saturated  = area_q_ff[AREA_W];
            end else if (q_in.valid) begin
               status.pop = 1'b1;
               item_in    = q_in.item;
               unique case (q_in.item.op)
                  OP_LOAD: begin
                     if (in_range(q_in.item.ia)) begin
                        pos_we  = 1'b1;
                        area_we = 1'b1;
                        area_wa = q_in.item.ia[ADDR_W-1:0];
                     end
                  end
                  OP_TRI: begin
                     if (in_range(q_in.item.ia) && in_range(q_in.item.ib) &&
                         in_range(q_in.item.ic)) begin
                        state_in = S_RD_A;
                     end
                  end
                  OP_READ: begin
                     if (in_range(q_in.item.ia)) begin
                        area_ra     = q_in.item.ia[ADDR_W-1:0];
                        rsp_pend_in = 1'b1;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = '0;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RD_A: begin
            pos_ra   = item_ff.ia[ADDR_W-1:0];
            state_in = S_RD_B;
         end
         S_RD_B: begin
            pos_ra   = item_ff.ib[ADDR_W-1:0];
            pa_in    = pos_q_ff;
            state_in = S_RD_C;
         end
         S_RD_C: begin
            pos_ra   = item_ff.ic[ADDR_W-1:0];
            pb_in    = pos_q_ff;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            for (int m = 0; m < 3; m++) begin
               u_in[m] = crd(pb_ff, m) - crd(pa_ff, m);
               v_in[m] = crd(pos_q_ff, m) - crd(pa_ff, m);
               w_in[m] = crd(pos_q_ff, m) - crd(pb_ff, m);
            end
            for (int i = 0; i < 9; i++) begin
               acc_in[i] = '0;
            end
            phase2_in = 1'b0;
            k_in      = 2'd0;
            j_in      = 3'd0;
            state_in  = S_DOT;
         end
         S_DOT: begin
            acc_in[dot_dst] = dot_neg ? acc_ff[dot_dst] - dot_ext : acc_ff[dot_dst] + dot_ext;
            j_in = (j_ff == 3'd5) ? 3'd0 : j_ff + 3'd1;
            if (j_ff == 3'd5) begin
               if (phase2_ff) begin
                  job_in   = 3'd0;
                  state_in = S_MLOAD;
               end else if (k_ff == 2'd2) begin
                  phase2_in = 1'b1;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         S_MLOAD: begin
            unique case (job_ff)
               3'd0: begin mac_a_in = mag(acc_ff[6]); mac_b_in = mag(acc_ff[6]); end
               3'd1: begin mac_a_in = mag(acc_ff[7]); mac_b_in = mag(acc_ff[7]); end
               3'd2: begin mac_a_in = mag(acc_ff[8]); mac_b_in = mag(acc_ff[8]); end
               3'd3: begin mac_a_in = acc_ff[0]; mac_b_in = acc_ff[5]; end
               3'd4: begin mac_a_in = acc_ff[1]; mac_b_in = acc_ff[4]; end
               default: begin mac_a_in = acc_ff[2]; mac_b_in = acc_ff[3]; end
            endcase
            if ((job_ff == 3'd0) || (job_ff >= 3'd3)) begin
               mac_acc_in = '0;
            end
            part_in  = 2'd0;
            state_in = S_MRUN;
         end
         S_MRUN: begin
            mac_acc_in = mac_next;
            part_in    = part_ff + 2'd1;
            if (part_ff == 2'd3) begin
               job_in   = job_ff + 3'd1;
               state_in = S_MLOAD;
               unique case (job_ff)
                  3'd2: begin
                     n_in     = mac_next;
                     root_in  = '0;
                     srem_in  = '0;
                     cnt_in   = CNT_W'(ACC_W - 1);
                     state_in = S_SQRT;
                  end
                  3'd3: t_in[0] = mac_next;
                  3'd4: t_in[1] = mac_next;
                  3'd5: begin
                     t_in[2]   = mac_next;
                     corner_in = 2'd0;
                     state_in  = S_CORNER;
                  end
                  default: job_in = job_ff + 3'd1;
               endcase
            end
         end
         S_SQRT: begin
            n_in = n_ff << 2;
            if (srem_sh >= strial) begin
               srem_in = srem_sh - strial;
               root_in = {root_ff[ACC_W-2:0], 1'b1};
            end else begin
               srem_in = srem_sh;
               root_in = {root_ff[ACC_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            acute_in  = positive(acc_ff[3]) && positive(acc_ff[4]) && positive(acc_ff[5]);
            corner_in = 2'd0;
            job_in    = 3'd3;
            if (root_ff == '0) begin
               state_in = S_IDLE;
            end else if (positive(acc_ff[3]) && positive(acc_ff[4]) &&
                         positive(acc_ff[5])) begin
               state_in = S_MLOAD;
            end else begin
               state_in = S_CORNER;
            end
         end
         S_CORNER: begin
            if (acute_ff) begin
               unique case (corner_ff)
                  2'd0:    num_in = t_ff[0] + t_ff[1];
                  2'd1:    num_in = t_ff[0] + t_ff[2];
                  default: num_in = t_ff[1] + t_ff[2];
               endcase
               drem_in  = '0;
               quot_in  = '0;
               dover_in = 1'b0;
               cnt_in   = CNT_W'(WIDE_W - 1);
               state_in = S_DIV;
            end else begin
               g_in = (dcor[ACC_W-1] || (dcor == '0)) ?
                      AREA_W'({root_ff[ACC_W-1:DEN_SHIFT], 1'b0}) :
                      AREA_W'(root_ff[ACC_W-1:DEN_SHIFT]);
               gover_in = 1'b0;
               state_in = S_RMW_RD;
            end
         end
         S_DIV: begin
            num_in   = num_ff << 1;
            drem_in  = dge ? dr_sub[DEN_W-1:0] : dr[DEN_W-1:0];
            dover_in = dover_nx;
            quot_in  = quot_nx;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               g_in     = dover_nx ? '1 : quot_nx;
               gover_in = dover_nx;
               state_in = S_RMW_RD;
            end
         end
         S_RMW_RD: begin
            area_ra  = cid[ADDR_W-1:0];
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            area_we = 1'b1;
            area_wa = cid[ADDR_W-1:0];
            if (gover_ff || gsum[AREA_W]) begin
               area_wd = {1'b1, {AREA_W{1'b1}}};
            end else begin
               area_wd = {area_q_ff[AREA_W], gsum[AREA_W-1:0]};
            end
            corner_in = corner_ff + 2'd1;
            state_in  = (corner_ff == 2'd2) ? S_IDLE : S_CORNER;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_pend_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_pend_ff   <= rsp_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      item_ff    <= item_in;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      for (int i = 0; i < 3; i++) begin
         u_ff[i] <= u_in[i];
         v_ff[i] <= v_in[i];
         w_ff[i] <= w_in[i];
         t_ff[i] <= t_in[i];
      end
      for (int i = 0; i < 9; i++) begin
         acc_ff[i] <= acc_in[i];
      end
      phase2_ff  <= phase2_in;
      k_ff       <= k_in;
      j_ff       <= j_in;
      mac_a_ff   <= mac_a_in;
      mac_b_ff   <= mac_b_in;
      part_ff    <= part_in;
      job_ff     <= job_in;
      mac_acc_ff <= mac_acc_in;
      n_ff       <= n_in;
      root_ff    <= root_in;
      srem_ff    <= srem_in;
      cnt_ff     <= cnt_in;
      acute_ff   <= acute_in;
      num_ff     <= num_in;
      drem_ff    <= drem_in;
      quot_ff    <= quot_in;
      dover_ff   <= dover_in;
      g_ff       <= g_in;
      gover_ff   <= gover_in;
      corner_ff  <= corner_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff) else $error("back-to-back responses");
   a_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW_WR && area_q_ff[AREA_W]) |-> area_wd[AREA_W])
      else $error("saturation mark lost");
   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      $fell(status.clearing) |-> (state_ff == S_RSP_ALIAS))
      else $error("clear sweep left to wrong state");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> (!rsp_pend_ff && q_in.valid)) else $error("bad queue pop");

endmodule
